FILE: rtl/core/vta_pkg.sv
// shared types and constants for the vertex transform pipeline
package vta_pkg;

    localparam int FRAC_BITS_DEF = 15;
    localparam int PROJ_BIAS_Z   = 64;
    localparam int PROJ_BIAS_Y   = 16;
    localparam int DVD_W         = 32;
    localparam int DSR_W         = 16;
    localparam int DIV_STEPS     = 4;
    localparam int DIV_STAGES    = DVD_W / DIV_STEPS;
    localparam int LATENCY       = DIV_STAGES + 4;

    typedef enum logic [2:0] {
        OP_ROT_X     = 3'd0,
        OP_ROT_Y     = 3'd1,
        OP_ROT_Z     = 3'd2,
        OP_TRANSLATE = 3'd3,
        OP_PROJECT   = 3'd4
    } op_t;

    typedef struct packed {
        logic               proj;
        logic               div_err;
        logic [15:0]        rx;
        logic [15:0]        ry;
        logic [15:0]        rz;
        logic               neg_x;
        logic               neg_y;
        logic [15:0]        off_x;
        logic [15:0]        off_y;
        logic [DSR_W-1:0]   dsr;
        logic [DVD_W-1:0]   dvd_x;
        logic [DVD_W-1:0]   dvd_y;
        logic [DSR_W-1:0]   rem_x;
        logic [DSR_W-1:0]   rem_y;
    } pipe_t;

endpackage

FILE: rtl/core/vta_front.sv
// operand select, multiply and combine stages
module vta_front
    import vta_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [2:0]         req_type,
    input  logic signed [15:0] in_x,
    input  logic signed [15:0] in_y,
    input  logic signed [15:0] in_z,
    input  logic signed [16:0] arg_a,
    input  logic signed [16:0] arg_b,
    input  logic signed [15:0] arg_c,
    input  logic signed [15:0] arg_d,
    output logic               pipe_valid,
    output pipe_t              pipe
);

    // stage 1
    logic               v1_reg;
    logic [2:0]         op1_reg;
    logic signed [15:0] x1_reg, y1_reg, z1_reg, c1_reg, d1_reg;
    logic signed [16:0] ma1_reg, mb1_reg, mu1_reg, mw1_reg, dz1_reg;
    logic signed [16:0] mu1_next, mw1_next, yb1;

    always_comb
    begin
        yb1 = 17'(in_y) + 17'sd16;
        case (req_type)
            OP_ROT_X:
            begin
                mu1_next = 17'(in_y);
                mw1_next = 17'(in_z);
            end
            OP_ROT_Y:
            begin
                mu1_next = 17'(in_x);
                mw1_next = 17'(in_z);
            end
            OP_PROJECT:
            begin
                mu1_next = 17'(in_x);
                mw1_next = yb1;
            end
            default:
            begin
                mu1_next = 17'(in_x);
                mw1_next = 17'(in_y);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= req_type;
        x1_reg  <= in_x;
        y1_reg  <= in_y;
        z1_reg  <= in_z;
        c1_reg  <= arg_c;
        d1_reg  <= arg_d;
        ma1_reg <= arg_a;
        mb1_reg <= arg_b;
        mu1_reg <= mu1_next;
        mw1_reg <= mw1_next;
        dz1_reg <= 17'(in_z) + 17'sd64;
    end

    // stage 2: products
    logic               v2_reg;
    logic [2:0]         op2_reg;
    logic signed [15:0] x2_reg, y2_reg, z2_reg, c2_reg, d2_reg;
    logic signed [16:0] a2_reg, b2_reg, dz2_reg;
    logic signed [33:0] p0_reg, p1_reg, p2_reg, p3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op2_reg <= op1_reg;
        x2_reg  <= x1_reg;
        y2_reg  <= y1_reg;
        z2_reg  <= z1_reg;
        c2_reg  <= c1_reg;
        d2_reg  <= d1_reg;
        a2_reg  <= ma1_reg;
        b2_reg  <= mb1_reg;
        dz2_reg <= dz1_reg;
        p0_reg  <= ma1_reg * mu1_reg;
        p1_reg  <= mb1_reg * mw1_reg;
        p2_reg  <= mb1_reg * mu1_reg;
        p3_reg  <= ma1_reg * mw1_reg;
    end

    // stage 3: combine, set up division
    logic signed [34:0] diff3, sum3;
    logic [15:0]        rd3, rs3;
    logic [33:0]        abs_x3, abs_y3;
    logic [16:0]        abs_d3;
    logic               pv_reg;
    pipe_t              pipe_reg, pipe_next;

    always_comb
    begin
        diff3  = 35'(p0_reg) - 35'(p1_reg);
        sum3   = 35'(p2_reg) + 35'(p3_reg);
        rd3    = diff3[FRAC_BITS +: 16];
        rs3    = sum3[FRAC_BITS +: 16];
        abs_x3 = p0_reg[33] ? 34'(-p0_reg) : 34'(p0_reg);
        abs_y3 = p1_reg[33] ? 34'(-p1_reg) : 34'(p1_reg);
        abs_d3 = dz2_reg[16] ? 17'(-dz2_reg) : 17'(dz2_reg);

        pipe_next         = '0;
        pipe_next.rx      = x2_reg;
        pipe_next.ry      = y2_reg;
        pipe_next.rz      = z2_reg;
        pipe_next.proj    = (op2_reg == OP_PROJECT);
        pipe_next.div_err = (op2_reg == OP_PROJECT) && (dz2_reg == 17'sd0);
        pipe_next.neg_x   = p0_reg[33] ^ dz2_reg[16];
        pipe_next.neg_y   = p1_reg[33] ^ dz2_reg[16];
        pipe_next.off_x   = c2_reg;
        pipe_next.off_y   = d2_reg;
        pipe_next.dsr     = abs_d3[DSR_W-1:0];
        pipe_next.dvd_x   = abs_x3[DVD_W-1:0];
        pipe_next.dvd_y   = abs_y3[DVD_W-1:0];

        case (op2_reg)
            OP_ROT_X:
            begin
                pipe_next.ry = rd3;
                pipe_next.rz = rs3;
            end
            OP_ROT_Y:
            begin
                pipe_next.rx = rd3;
                pipe_next.rz = rs3;
            end
            OP_ROT_Z:
            begin
                pipe_next.rx = rd3;
                pipe_next.ry = rs3;
            end
            OP_TRANSLATE:
            begin
                pipe_next.rx = x2_reg + a2_reg[15:0];
                pipe_next.ry = y2_reg + b2_reg[15:0];
                pipe_next.rz = z2_reg + c2_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg <= pipe_next;
    end

    assign pipe_valid = pv_reg;
    assign pipe       = pipe_reg;

endmodule

FILE: rtl/core/vta_div_stage.sv
// one stage of the restoring divider, DIV_STEPS (four) quotient bits per lane
module vta_div_stage
    import vta_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  pipe_t in_pipe,
    output logic  out_valid,
    output pipe_t out_pipe
);

    logic  valid_reg;
    pipe_t pipe_reg, pipe_next;
    logic [DSR_W:0] rx, ry;

    always_comb
    begin
        pipe_next = in_pipe;
        rx = '0;
        ry = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rx = {pipe_next.rem_x, pipe_next.dvd_x[DVD_W-1]};
            ry = {pipe_next.rem_y, pipe_next.dvd_y[DVD_W-1]};
            pipe_next.dvd_x = {pipe_next.dvd_x[DVD_W-2:0], 1'b0};
            pipe_next.dvd_y = {pipe_next.dvd_y[DVD_W-2:0], 1'b0};
            if (rx >= {1'b0, pipe_next.dsr})
            begin
                rx = rx - {1'b0, pipe_next.dsr};
                pipe_next.dvd_x[0] = 1'b1;
            end
            if (ry >= {1'b0, pipe_next.dsr})
            begin
                ry = ry - {1'b0, pipe_next.dsr};
                pipe_next.dvd_y[0] = 1'b1;
            end
            pipe_next.rem_x = rx[DSR_W-1:0];
            pipe_next.rem_y = ry[DSR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

FILE: rtl/core/vertex_transform_alu.sv
// vertex transform top level: rotate, translate or project one vertex per cycle
// pipeline from start to done: 3 front stages, 8 divider stages, output register
// throughput: one transaction per cycle, the 32-bit divider is fully pipelined
// busy stays low; results appear on done for one cycle and cannot be stalled
// reset clears all valid bits, so no done is seen until a new start
module vertex_transform_alu
    import vta_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic signed [15:0] in_x,
    input  logic signed [15:0] in_y,
    input  logic signed [15:0] in_z,
    input  logic signed [16:0] arg_a,
    input  logic signed [16:0] arg_b,
    input  logic signed [15:0] arg_c,
    input  logic signed [15:0] arg_d,
    output logic               done,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic               div_error
);

    logic  sv [0:DIV_STAGES];
    pipe_t sp [0:DIV_STAGES];

    assign busy = 1'b0;

    vta_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .req_type   (req_type),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_z       (in_z),
        .arg_a      (arg_a),
        .arg_b      (arg_b),
        .arg_c      (arg_c),
        .arg_d      (arg_d),
        .pipe_valid (sv[0]),
        .pipe       (sp[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        vta_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sv[g]),
            .in_pipe   (sp[g]),
            .out_valid (sv[g+1]),
            .out_pipe  (sp[g+1])
        );
    end

    pipe_t       fin;
    logic [15:0] qx, qy, px, py;
    logic        done_reg;
    logic [15:0] x_reg, y_reg, z_reg, x_next, y_next;
    logic        err_reg;

    always_comb
    begin
        fin = sp[DIV_STAGES];
        qx  = fin.dvd_x[15:0];
        qy  = fin.dvd_y[15:0];
        px  = fin.neg_x ? 16'(-(qx + 16'(fin.rem_x != '0))) : qx;
        py  = fin.neg_y ? 16'(-(qy + 16'(fin.rem_y != '0))) : qy;
        if (!fin.proj)
        begin
            x_next = fin.rx;
            y_next = fin.ry;
        end
        else if (fin.div_err)
        begin
            x_next = fin.off_x;
            y_next = fin.off_y;
        end
        else
        begin
            x_next = px + fin.off_x;
            y_next = py + fin.off_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sv[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= fin.rz;
        err_reg <= fin.div_err;
    end

    assign done      = done_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign div_error = err_reg;

endmodule

FILE: rtl/core/vta_checker.sv
// port-level checks for the vertex transform block
module vta_checker
    import vta_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [2:0]         req_type,
    input logic               done,
    input logic signed [15:0] out_z,
    input logic               div_error
);

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done without matching transaction");

    a_err_proj: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_error) |-> ($past(req_type, LATENCY) == OP_PROJECT))
        else $error("div_error on non-projection");

    a_err_z: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_error) |-> (out_z == -16'sd64))
        else $error("div_error with nonzero divisor");

endmodule

bind vertex_transform_alu vta_checker u_vta_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .done      (done),
    .out_z     (out_z),
    .div_error (div_error)
);

FILE: dv/vertex_transform_checker.sv
// checker for the vertex transform block: predicts each vertex and compares results
module vertex_transform_checker
    import vta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         req_type,
    input  logic signed [15:0] in_x,
    input  logic signed [15:0] in_y,
    input  logic signed [15:0] in_z,
    input  logic signed [16:0] arg_a,
    input  logic signed [16:0] arg_b,
    input  logic signed [15:0] arg_c,
    input  logic signed [15:0] arg_d,
    input  logic               done,
    input  logic signed [15:0] out_x,
    input  logic signed [15:0] out_y,
    input  logic signed [15:0] out_z,
    input  logic               div_error,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        err;
    } vertex_t;

    vertex_t vertex_q[$];

    function automatic longint floor_shift(longint v, int s);
        longint d;
        d = longint'(1) << s;
        if (v >= 0)
            return v / d;
        return -((-v + d - 1) / d);
    endfunction

    function automatic longint project_axis(longint mag, longint v, longint dv, longint offs);
        longint num;
        num = mag * v * 65536;
        return floor_shift(num / dv, PROJ_BIAS_Y) + offs;
    endfunction

    function automatic vertex_t transform_vertex(logic [2:0] op, longint x, longint y,
                                                 longint z, longint a, longint b,
                                                 longint c, longint d);
        longint rx, ry, rz, dv;
        vertex_t v;
        rx = x;
        ry = y;
        rz = z;
        v.err = 1'b0;
        case (op)
            OP_ROT_X:
            begin
                ry = floor_shift(a * y - b * z, FRAC_BITS_DEF);
                rz = floor_shift(b * y + a * z, FRAC_BITS_DEF);
            end
            OP_ROT_Y:
            begin
                rx = floor_shift(a * x - b * z, FRAC_BITS_DEF);
                rz = floor_shift(b * x + a * z, FRAC_BITS_DEF);
            end
            OP_ROT_Z:
            begin
                rx = floor_shift(a * x - b * y, FRAC_BITS_DEF);
                ry = floor_shift(b * x + a * y, FRAC_BITS_DEF);
            end
            OP_TRANSLATE:
            begin
                rx = x + a;
                ry = y + b;
                rz = z + c;
            end
            OP_PROJECT:
            begin
                dv = z + PROJ_BIAS_Z;
                if (dv == 0)
                begin
                    rx = c;
                    ry = d;
                    v.err = 1'b1;
                end
                else
                begin
                    rx = project_axis(a, x, dv, c);
                    ry = project_axis(b, y + PROJ_BIAS_Y, dv, d);
                end
            end
            default:
            begin
            end
        endcase
        v.x = rx[15:0];
        v.y = ry[15:0];
        v.z = rz[15:0];
        return v;
    endfunction

    assign pending = vertex_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        vertex_t want;
        if (!rst_n)
        begin
            vertex_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (vertex_q.size() == 0)
                begin
                    $display("%t unexpected transaction: x=%h y=%h z=%h err=%b", $realtime,
                             out_x, out_y, out_z, div_error);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = vertex_q.pop_front();
                    if (want.x !== out_x || want.y !== out_y || want.z !== out_z
                        || want.err !== div_error)
                    begin
                        $display("%t mismatch: expected x=%h y=%h z=%h err=%b", $realtime,
                                 want.x, want.y, want.z, want.err);
                        $display("%t           actual   x=%h y=%h z=%h err=%b", $realtime,
                                 out_x, out_y, out_z, div_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                vertex_q.push_back(transform_vertex(req_type, in_x, in_y, in_z,
                                                    arg_a, arg_b, arg_c, arg_d));
        end
    end
endmodule

FILE: dv/vertex_transform_alu_tb.sv
// testbench top for the vertex transform block: stimulus and verdict
module vertex_transform_alu_tb;
    import vta_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         req_type;
    logic signed [15:0] in_x, in_y, in_z, arg_c, arg_d;
    logic signed [16:0] arg_a, arg_b;
    logic               done;
    logic signed [15:0] out_x, out_y, out_z;
    logic               div_error;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    bit                 no_idle;

    vertex_transform_alu uut (.*);

    vertex_transform_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 200000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic signed [16:0] rand_arg();
        case ($urandom_range(0, 5))
            0: return 17'sd32768;
            1: return -17'sd32768;
            2: return 17'($urandom);
            default: return 17'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(-64 + $urandom_range(0, 4) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(logic [2:0] op, logic signed [15:0] x, logic signed [15:0] y,
                        logic signed [15:0] z, logic signed [16:0] a,
                        logic signed [16:0] b, logic signed [15:0] c,
                        logic signed [15:0] d);
        while (!no_idle && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= op;
        in_x     <= x;
        in_y     <= y;
        in_z     <= z;
        arg_a    <= a;
        arg_b    <= b;
        arg_c    <= c;
        arg_d    <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [2:0] op;
        op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        send(op, rand_coord(), rand_coord(), rand_coord(), rand_arg(), rand_arg(),
             16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int n;
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = '0;
        in_x     = '0;
        in_y     = '0;
        in_z     = '0;
        arg_a    = '0;
        arg_b    = '0;
        arg_c    = '0;
        arg_d    = '0;
        no_idle  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_ROT_X, 16'sh7fff, 16'sh8000, 16'sh7fff, 17'sd32768, -17'sd32768,
             16'sd0, 16'sd0);
        send(OP_ROT_Y, 16'sh8000, 16'sh7fff, 16'sh8000, -17'sd32768, 17'sd32768,
             16'sd0, 16'sd0);
        send(OP_ROT_Z, 16'sh8000, 16'sh8000, 16'sd5, 17'sd23170, 17'sd23170,
             16'sd0, 16'sd0);
        send(OP_ROT_Z, 16'sd100, -16'sd100, 16'sd0, 17'h1ffff, 17'h10000,
             16'sd0, 16'sd0);
        send(OP_TRANSLATE, 16'sh7fff, 16'sh8000, 16'sh7fff, 17'sd32768, -17'sd32768,
             16'sh7fff, 16'sh1234);
        send(OP_TRANSLATE, 16'sh8000, 16'sh7fff, 16'sh8000, -17'sd32768, 17'sd32767,
             16'sh8000, 16'sh0);
        send(OP_PROJECT, 16'sd100, 16'sd50, -16'sd64, 17'sd256, 17'sd256,
             16'sd160, 16'sd120);
        send(OP_PROJECT, 16'sh7fff, 16'sh7fff, -16'sd63, 17'sd32768, 17'sd32768,
             16'sh7fff, 16'sh7fff);
        send(OP_PROJECT, 16'sh8000, 16'sh8000, -16'sd65, -17'sd32768, -17'sd32768,
             16'sh8000, 16'sh8000);
        send(OP_PROJECT, -16'sd7, -16'sd17, 16'sh7fff, 17'sd3, -17'sd3,
             16'sd0, 16'sd0);
        send(OP_PROJECT, 16'sd1, -16'sd16, 16'sh8000, 17'sd1, 17'sd1,
             16'sd0, 16'sd0);
        send(3'd5, 16'sh1111, 16'sh2222, 16'sh3333, 17'sd1, 17'sd1, 16'sd1, 16'sd1);
        send(3'd6, 16'sh8000, 16'sh7fff, 16'sh0, 17'sd1, 17'sd1, 16'sd1, 16'sd1);
        send(3'd7, 16'sh7fff, 16'sh8000, -16'sd64, 17'sd1, 17'sd1, 16'sd1, 16'sd1);

        // wait for the pipeline to drain completely
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        for (n = 0; n < 1300; n++)
        begin
            no_idle = (n >= 400 && n < 600);
            send_random();
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/vta_pkg.sv
rtl/core/vta_front.sv
rtl/core/vta_div_stage.sv
rtl/core/vertex_transform_alu.sv
rtl/core/vta_checker.sv
dv/vertex_transform_checker.sv
dv/vertex_transform_alu_tb.sv
